FILE: sv/amg_soc_pkg.sv
// ----------------------------------------------------------------------------
// amg_soc_pkg
// Shared types and constants of the strength-of-connection block.
// ----------------------------------------------------------------------------
`default_nettype none

package amg_soc_pkg;

  // field widths
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 32;
  localparam int TOTAL_W = 6;
  localparam int TF_W    = 17;
  localparam int MAG_W   = 2 * VAL_W;
  localparam int THR_W   = MAG_W + TF_W;
  localparam int FRAC_W  = 16;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_COMPLEX   = 1'b1;
  localparam logic [TF_W-1:0] TF_RESET = 17'd16384;

  // register set seen by the sequencer
  typedef struct packed {
    logic [TF_W-1:0] threshold_factor;
    logic            complex_mode;
  } cfg_t;

  // write side of the row buffer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] col;
    logic [MAG_W-1:0] mag;
  } mem_wr_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_RE,
    S_SQ_IM,
    S_WRITE,
    S_MAX_RD,
    S_MAX_CHK,
    S_THR_LO,
    S_THR_HI,
    S_THR_SUM,
    S_CNT_RD,
    S_CNT_CHK,
    S_EMT_RD,
    S_EMT_CHK,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: sv/amg_soc_if.sv
// ----------------------------------------------------------------------------
// amg_soc_if
// Valid/ready channels for matrix entries and strong-connection results.
// ----------------------------------------------------------------------------
`default_nettype none

interface amg_soc_entry_if
  import amg_soc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_number;
  logic [IDX_W-1:0] column_number;
  logic [VAL_W-1:0] real_part;
  logic [VAL_W-1:0] imag_part;
  logic             row_end;

  modport source (
    output valid, row_number, column_number, real_part, imag_part, row_end,
    input  ready
  );
  modport sink (
    input  valid, row_number, column_number, real_part, imag_part, row_end,
    output ready
  );
endinterface

interface amg_soc_result_if
  import amg_soc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   out_row;
  logic [IDX_W-1:0]   strong_column;
  logic               column_valid;
  logic [TOTAL_W-1:0] strong_total;
  logic               overflow_flag;
  logic               last_of_row;

  modport source (
    output valid, out_row, strong_column, column_valid, strong_total,
           overflow_flag, last_of_row,
    input  ready
  );
  modport sink (
    input  valid, out_row, strong_column, column_valid, strong_total,
           overflow_flag, last_of_row,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/amg_soc_mul.sv
// ----------------------------------------------------------------------------
// amg_soc_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module amg_soc_mul
  import amg_soc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [VAL_W-1:0] a,
  input  wire logic [VAL_W-1:0] b,
  output logic      [MAG_W-1:0] p
);

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    p <= MAG_W'(a) * MAG_W'(b);
  end

endmodule

`default_nettype wire

FILE: sv/amg_soc_buf.sv
// ----------------------------------------------------------------------------
// amg_soc_buf
// Row buffer holding column and magnitude of each stored entry.
// ----------------------------------------------------------------------------
`default_nettype none

module amg_soc_buf
  import amg_soc_pkg::*;
#(
  parameter int ROW_ENTRIES = 32,
  parameter int AW          = 5
) (
  input  wire logic             clk,
  input  wire mem_wr_t          wr,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [AW-1:0]    raddr,
  output logic      [IDX_W-1:0] rd_col,
  output logic      [MAG_W-1:0] rd_mag
);

  logic [IDX_W-1:0] col_mem [ROW_ENTRIES];
  logic [MAG_W-1:0] mag_mem [ROW_ENTRIES];

  // single write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      col_mem[waddr] <= wr.col;
      mag_mem[waddr] <= wr.mag;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_col <= col_mem[raddr];
    rd_mag <= mag_mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/amg_soc_ctrl.sv
// ----------------------------------------------------------------------------
// amg_soc_ctrl
// Sequencer: buffers entries, then runs max, count and emit passes.
// ----------------------------------------------------------------------------
`default_nettype none

module amg_soc_ctrl
  import amg_soc_pkg::*;
#(
  parameter int ROW_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  amg_soc_entry_if.sink    entries,
  amg_soc_result_if.source results
);

  localparam int AW = $clog2(ROW_ENTRIES);
  localparam int CW = $clog2(ROW_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ROW_ENTRIES);

  state_t state, state_next;

  logic [CW-1:0]    fill;
  logic             dropped;
  logic [IDX_W-1:0] row;
  logic             row_end_q;
  logic [IDX_W-1:0] col_q;
  logic [VAL_W-1:0] re_abs;
  logic [VAL_W-1:0] im_abs;
  logic [MAG_W-1:0] sq_re;
  logic [CW-1:0]    k;
  logic [MAG_W-1:0] max_mag;
  logic [THR_W-1:0] thr;
  logic [CW-1:0]    total;
  logic [CW-1:0]    emitted;

  // output register
  logic               o_valid;
  logic [IDX_W-1:0]   o_row;
  logic [IDX_W-1:0]   o_col;
  logic               o_cv;
  logic [TOTAL_W-1:0] o_total;
  logic               o_ovf;
  logic               o_last;

  logic [VAL_W-1:0] mul_a;
  logic [VAL_W-1:0] mul_b;
  logic [MAG_W-1:0] mul_p;
  mem_wr_t          wr;
  logic [IDX_W-1:0] rd_col;
  logic [MAG_W-1:0] rd_mag;

  logic             accept;
  logic             out_free;
  logic             offdiag;
  logic             above_thr;
  logic             k_last;
  logic             emit_strong;
  logic             emit_empty;
  logic [CW-1:0]    k_inc;

  // shared multiplier and row buffer
  amg_soc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  amg_soc_buf #(
    .ROW_ENTRIES (ROW_ENTRIES),
    .AW          (AW)
  ) u_buf (
    .clk    (clk),
    .wr     (wr),
    .waddr  (fill[AW-1:0]),
    .raddr  (k[AW-1:0]),
    .rd_col (rd_col),
    .rd_mag (rd_mag)
  );

  // status of the entry just read back
  assign accept    = entries.valid && entries.ready;
  assign out_free  = !o_valid || results.ready;
  assign offdiag   = (rd_col != row);
  assign above_thr = offdiag && ({1'b0, rd_mag, FRAC_W'(0)} > thr);
  assign k_inc     = CW'(k + 1'b1);
  assign k_last    = (k_inc == fill);
  assign emit_strong = (state == S_EMT_CHK) && above_thr && out_free;
  assign emit_empty  = (state == S_FIN) && (emitted == '0) && out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (fill != FULL) begin
            state_next = S_SQ_RE;
          end else if (entries.row_end) begin
            state_next = S_MAX_RD;
          end
        end
      end
      S_SQ_RE:   state_next = S_SQ_IM;
      S_SQ_IM:   state_next = S_WRITE;
      S_WRITE:   state_next = row_end_q ? S_MAX_RD : S_IDLE;
      S_MAX_RD:  state_next = S_MAX_CHK;
      S_MAX_CHK: state_next = k_last ? S_THR_LO : S_MAX_RD;
      S_THR_LO:  state_next = S_THR_HI;
      S_THR_HI:  state_next = S_THR_SUM;
      S_THR_SUM: state_next = S_CNT_RD;
      S_CNT_RD:  state_next = S_CNT_CHK;
      S_CNT_CHK: state_next = k_last ? S_EMT_RD : S_CNT_RD;
      S_EMT_RD:  state_next = S_EMT_CHK;
      S_EMT_CHK: begin
        if (!(above_thr && !out_free)) begin
          state_next = k_last ? S_FIN : S_EMT_RD;
        end
      end
      S_FIN: begin
        if ((emitted != '0) || out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // state-driven controls: handshake, multiplier operands, buffer write
  always_comb begin
    entries.ready = (state == S_IDLE) && !rst;
    mul_a  = '0;
    mul_b  = '0;
    wr.we  = (state == S_WRITE);
    wr.col = col_q;
    wr.mag = cfg.complex_mode ? (sq_re + mul_p) : MAG_W'(re_abs);
    unique case (state)
      S_SQ_RE: begin
        mul_a = re_abs;
        mul_b = re_abs;
      end
      S_SQ_IM: begin
        mul_a = im_abs;
        mul_b = im_abs;
      end
      S_THR_LO: begin
        mul_a = max_mag[VAL_W-1:0];
        mul_b = VAL_W'(cfg.threshold_factor);
      end
      S_THR_HI: begin
        mul_a = max_mag[MAG_W-1:VAL_W];
        mul_b = VAL_W'(cfg.threshold_factor);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      dropped <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (fill == FULL)) begin
        dropped <= 1'b1;
      end
      if (state == S_WRITE) begin
        fill <= CW'(fill + 1'b1);
      end
      if ((state == S_FIN) && (state_next == S_IDLE)) begin
        fill    <= '0;
        dropped <= 1'b0;
      end
      if (emit_strong || emit_empty) begin
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row       <= entries.row_number;
      col_q     <= entries.column_number;
      row_end_q <= entries.row_end;
      re_abs    <= entries.real_part[VAL_W-1] ? (~entries.real_part + 1'b1)
                                              : entries.real_part;
      im_abs    <= entries.imag_part[VAL_W-1] ? (~entries.imag_part + 1'b1)
                                              : entries.imag_part;
    end
    // square of the real part, kept while the imaginary part is squared
    if (state == S_SQ_IM) begin
      sq_re <= mul_p;
    end
    // passes start from the first buffered entry
    if ((state == S_IDLE) || (state == S_WRITE)) begin
      k       <= '0;
      max_mag <= '0;
    end
    // largest off-diagonal magnitude
    if (state == S_MAX_CHK) begin
      if (offdiag && (rd_mag > max_mag)) begin
        max_mag <= rd_mag;
      end
      k     <= k_last ? '0 : k_inc;
      total <= '0;
    end
    // threshold = theta * max, built from two partial products
    if (state == S_THR_HI) begin
      thr <= THR_W'(mul_p);
    end
    if (state == S_THR_SUM) begin
      thr <= thr + {mul_p[THR_W-VAL_W-1:0], VAL_W'(0)};
    end
    // count strong connections
    if (state == S_CNT_CHK) begin
      if (above_thr) begin
        total <= CW'(total + 1'b1);
      end
      k       <= k_last ? '0 : k_inc;
      emitted <= '0;
    end
    // emit pass, holding on a busy output register
    if ((state == S_EMT_CHK) && !(above_thr && !out_free)) begin
      k <= k_last ? '0 : k_inc;
    end
    if (emit_strong) begin
      emitted <= CW'(emitted + 1'b1);
      o_row   <= row;
      o_col   <= rd_col;
      o_cv    <= 1'b1;
      o_total <= TOTAL_W'(total);
      o_ovf   <= dropped;
      o_last  <= (CW'(emitted + 1'b1) == total);
    end
    if (emit_empty) begin
      o_row   <= row;
      o_col   <= '0;
      o_cv    <= 1'b0;
      o_total <= '0;
      o_ovf   <= dropped;
      o_last  <= 1'b1;
    end
  end

  // result channel
  assign results.valid         = o_valid;
  assign results.out_row       = o_row;
  assign results.strong_column = o_col;
  assign results.column_valid  = o_cv;
  assign results.strong_total  = o_total;
  assign results.overflow_flag = o_ovf;
  assign results.last_of_row   = o_last;

endmodule

`default_nettype wire

FILE: sv/amg_strength_of_connection.sv
// ----------------------------------------------------------------------------
// amg_strength_of_connection
// Classical AMG strength of connection for one sparse matrix row at a time.
// ----------------------------------------------------------------------------
// Entries of a row arrive one per item and are buffered (up to ROW_ENTRIES;
// further entries are dropped and reported through overflow_flag). An
// accepted entry goes through accept, squaring of real and imaginary parts on
// the shared 32x32 multiplier, and buffer write; a dropped entry is discarded
// at accept. After row_end the block runs max, count and emit passes over the
// buffered entries through the row buffer's single read port, reading then
// checking each; between the first two it forms theta times the maximum on the
// same multiplier from two partial products and a sum. A closing step ends the
// row; the emit pass holds while results stall. Results leave through an output
// register, so the next row's first entry is taken while the last result waits.
`default_nettype none

module amg_strength_of_connection
  import amg_soc_pkg::*;
#(
  parameter int ROW_ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  // item channels
  amg_soc_entry_if.sink          entries,
  amg_soc_result_if.source       results
);

  logic [TF_W-1:0] threshold_factor;
  logic            complex_mode;
  logic            cfg_write;
  cfg_t            cfg;

  // register writes
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_factor <= TF_RESET;
      complex_mode     <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD: threshold_factor <= pwdata[TF_W-1:0];
        REG_COMPLEX:   complex_mode     <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = APB_DW'(threshold_factor);
      REG_COMPLEX:   prdata = APB_DW'(complex_mode);
      default:       prdata = '0;
    endcase
  end

  assign cfg.threshold_factor = threshold_factor;
  assign cfg.complex_mode     = complex_mode;

  // sequencer with buffer and shared multiplier
  amg_soc_ctrl #(
    .ROW_ENTRIES (ROW_ENTRIES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .entries (entries),
    .results (results)
  );

`ifndef SYNTHESIS
  // an empty-row result carries no column and no count
  a_empty_result : assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.column_valid) |->
      (results.last_of_row && (results.strong_total == '0) &&
       (results.strong_column == '0)))
    else $error("empty-row result with stray fields");

  // a strong connection implies a nonzero count unless the count can wrap
  a_total_nonzero : assert property (@(posedge clk) disable iff (rst)
    ((ROW_ENTRIES < 64) && results.valid && results.column_valid) |->
      (results.strong_total != '0))
    else $error("strong connection reported with zero total");

  // closing a row keeps the block busy in the next cycle
  a_row_end_busy : assert property (@(posedge clk) disable iff (rst)
    (entries.valid && entries.ready && entries.row_end) |=> !entries.ready)
    else $error("entry taken right after a row end");

  // while results of a row remain, no new entry is taken
  a_row_in_flight : assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && !results.last_of_row) |=> !entries.ready)
    else $error("entry taken before the row was fully reported");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strength-of-connection block. Sparse rows are
// streamed in through the entry channel under random bursts and gaps. The
// result channel stalls in shifting patterns, with one long hold-off.
// Every accepted entry is fed to a scoreboard. At each row end it predicts
// the strong columns of that row, and each result is checked against it
// field by field. The threshold and mode registers are reprogrammed between
// phases while the block is idle, including the extreme thresholds.
// ----------------------------------------------------------------------------
module tb
  import amg_soc_pkg::*;
();

  localparam int BUF_DEPTH    = 32;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 132;
  localparam int PHASES       = 6;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] re;
    logic [VAL_W-1:0] im;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               valid;
    logic [TOTAL_W-1:0] total;
    logic               overflow;
    logic               last;
  } link_t;

  // row buffer mirror, strength prediction and result checking
  class strength_board;
    logic [TF_W-1:0]  theta;
    logic             complex_on;
    logic [IDX_W-1:0] held_col [BUF_DEPTH];
    logic [VAL_W-1:0] held_re [BUF_DEPTH];
    logic [VAL_W-1:0] held_im [BUF_DEPTH];
    int unsigned      fill;
    logic             dropped;
    link_t            expected_links[$];
    int unsigned      errors;
    int unsigned      entries_in;
    int unsigned      rows_closed;
    int unsigned      rows_dropped;
    int unsigned      links_checked;

    function new();
      theta         = TF_RESET;
      complex_on    = 1'b0;
      fill          = 0;
      dropped       = 1'b0;
      errors        = 0;
      entries_in    = 0;
      rows_closed   = 0;
      rows_dropped  = 0;
      links_checked = 0;
    endfunction

    // |re| in real mode, re^2 + im^2 in complex mode
    function logic [MAG_W-1:0] magnitude_of(int unsigned k);
      logic [VAL_W:0] ar;
      logic [VAL_W:0] ai;
      ar = held_re[k][VAL_W-1] ? ({1'b1, {VAL_W{1'b0}}} - {1'b0, held_re[k]})
                               : {1'b0, held_re[k]};
      ai = held_im[k][VAL_W-1] ? ({1'b1, {VAL_W{1'b0}}} - {1'b0, held_im[k]})
                               : {1'b0, held_im[k]};
      if (!complex_on) return MAG_W'(ar);
      return MAG_W'(ar) * MAG_W'(ar) + MAG_W'(ai) * MAG_W'(ai);
    endfunction

    // exact m > theta * max, theta in Q1.16
    function bit is_strong(logic [MAG_W-1:0] m, logic [MAG_W-1:0] peak);
      logic [THR_W-1:0] lhs;
      logic [THR_W-1:0] rhs;
      lhs = THR_W'({m, {FRAC_W{1'b0}}});
      rhs = THR_W'(peak) * THR_W'(theta);
      return lhs > rhs;
    endfunction

    function void note_entry(entry_t e);
      logic [MAG_W-1:0] peak;
      logic [MAG_W-1:0] m;
      int unsigned      total;
      int unsigned      emitted;
      int unsigned      k;
      link_t            r;
      entries_in++;
      if (fill < BUF_DEPTH) begin
        held_col[fill] = e.col;
        held_re[fill]  = e.re;
        held_im[fill]  = e.im;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!e.last) return;
      // largest off-diagonal magnitude, using the row of the closing item
      peak = '0;
      for (k = 0; k < fill; k++) begin
        m = magnitude_of(k);
        if (held_col[k] != e.row && m > peak) peak = m;
      end
      total = 0;
      for (k = 0; k < fill; k++)
        if (held_col[k] != e.row && is_strong(magnitude_of(k), peak)) total++;
      emitted = 0;
      for (k = 0; k < fill; k++) begin
        if (held_col[k] != e.row && is_strong(magnitude_of(k), peak)) begin
          r.row      = e.row;
          r.col      = held_col[k];
          r.valid    = 1'b1;
          r.total    = TOTAL_W'(total);
          r.overflow = dropped;
          r.last     = (emitted + 1 == total);
          expected_links.push_back(r);
          emitted++;
        end
      end
      // no strong connection: a single empty marker
      if (emitted == 0) begin
        r.row      = e.row;
        r.col      = '0;
        r.valid    = 1'b0;
        r.total    = '0;
        r.overflow = dropped;
        r.last     = 1'b1;
        expected_links.push_back(r);
      end
      rows_closed++;
      if (dropped) rows_dropped++;
      fill    = 0;
      dropped = 1'b0;
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_link(link_t got);
      link_t want;
      if (expected_links.size() == 0) begin
        $error("unexpected result: row %0d column %0d", got.row, got.col);
        errors++;
        return;
      end
      want = expected_links.pop_front();
      links_checked++;
      compare("out_row", 32'(want.row), 32'(got.row));
      compare("strong_column", 32'(want.col), 32'(got.col));
      compare("column_valid", 32'(want.valid), 32'(got.valid));
      compare("strong_total", 32'(want.total), 32'(got.total));
      compare("overflow_flag", 32'(want.overflow), 32'(got.overflow));
      compare("last_of_row", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              hold_request = 1'b0;
  int unsigned       idle_cycles  = 0;
  int unsigned       burst_left   = 0;
  int unsigned       random_sent  = 0;
  strength_board     board = new();

  amg_soc_entry_if  ent();
  amg_soc_result_if res();

  amg_strength_of_connection #(
    .ROW_ENTRIES(BUF_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .entries (ent),
    .results (res)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // one entry item, with bursts and random gaps between them
  task automatic push_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im,
                            input logic last);
    entry_t      e;
    int unsigned gap;
    e = '{row, col, re, im, last};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        ent.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    ent.valid         <= 1'b1;
    ent.row_number    <= row;
    ent.column_number <= col;
    ent.real_part     <= re;
    ent.imag_part     <= im;
    ent.row_end       <= last;
    @(posedge clk);
    while (!ent.ready) @(posedge clk);
    board.note_entry(e);
    burst_left--;
    @(negedge clk);
  endtask

  // register write followed by a read back
  task automatic set_register(input logic idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (idx == REG_THRESHOLD) board.theta = value[TF_W-1:0];
    else board.complex_on = value[0];
    if (readback !== value) begin
      $error("register read back: expected %0d, got %0d", value, readback);
      board.errors++;
    end
  endtask

  // stop offering, let every result out and the block settle
  task automatic drain();
    ent.valid <= 1'b0;
    while (board.expected_links.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(int unsigned style,
                                                  logic [VAL_W-1:0] base);
    logic [VAL_W-1:0] v;
    case (style)
      0: v = $urandom;
      1: begin
        v = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        // few distinct values, so ties and threshold boundaries turn up
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = base;
          2: v = -base;
          3: v = base >> 2;
          4: v = base >> 1;
          default: v = -(base >> 2);
        endcase
      end
    endcase
    return v;
  endfunction

  // one row of random content, closed by a row_end item
  task automatic random_row(input int unsigned len);
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] tag;
    logic [VAL_W-1:0] base;
    int unsigned      style;
    int unsigned      k;
    row   = IDX_W'($urandom_range(0, 4095));
    style = $urandom_range(0, 2);
    base  = VAL_W'($urandom_range(1, 1 << 20)) << 2;
    for (k = 0; k < len; k++) begin
      col = ($urandom_range(0, 5) == 0) ? row : IDX_W'($urandom_range(0, 4095));
      // row number of inner items is ignored, so make it noise
      tag = (k + 1 == len) ? row : IDX_W'($urandom);
      push_entry(tag, col, pick_value(style, base), pick_value(style, base), k + 1 == len);
      random_sent++;
    end
  endtask

  // result side readiness, with one long hold-off on request
  initial begin
    int unsigned stall_mode;
    int unsigned stall_left;
    stall_mode = 0;
    stall_left = 0;
    res.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        case (stall_mode)
          0: res.ready <= 1'b1;
          1: res.ready <= ($urandom_range(0, 3) != 0);
          2: res.ready <= ($urandom_range(0, 2) == 0);
          default: res.ready <= (stall_left % 3 == 0);
        endcase
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin : monitor
    link_t got;
    if (!rst && res.valid && res.ready) begin
      got = '{res.out_row, res.strong_column, res.column_valid, res.strong_total,
              res.overflow_flag, res.last_of_row};
      board.check_link(got);
    end
    if (rst || psel || (ent.valid && ent.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [TF_W-1:0] theta_list [PHASES];
    logic            mode_list [PHASES];
    int unsigned     p;
    int unsigned     len;
    theta_list = '{17'd16384, 17'd0, 17'd65536, 17'd131071,
                   TF_W'($urandom_range(1, 65535)), 17'd1};
    mode_list  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    ent.valid         = 1'b0;
    ent.row_number    = '0;
    ent.column_number = '0;
    ent.real_part     = '0;
    ent.imag_part     = '0;
    ent.row_end       = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, real mode: boundary at exactly theta times the maximum,
    // extreme values and columns, diagonal skipped
    push_entry(12'hFFF, 12'd7, 32'd5, 32'd0, 1'b0);
    push_entry(12'h000, 12'd3, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_entry(12'hA5A, 12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_entry(12'h5A5, 12'd0, 32'h2000_0000, 32'd0, 1'b0);
    push_entry(12'd7, 12'd9, 32'hDFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // diagonal only: empty row
    push_entry(12'd4095, 12'd4095, 32'h7FFF_FFFF, 32'd0, 1'b1);
    // only zero real parts: nothing strong
    push_entry(12'h5A5, 12'd1, 32'd0, 32'h7FFF_FFFF, 1'b0);
    push_entry(12'd0, 12'd2, 32'd0, 32'h8000_0000, 1'b1);
    drain();

    // theta of one in complex mode: nothing can exceed the maximum
    set_register(REG_THRESHOLD, 32'd65536);
    set_register(REG_COMPLEX, 32'd1);
    push_entry(12'd0, 12'd5, 32'h8000_0000, 32'h8000_0000, 1'b0);
    push_entry(12'd0, 12'd100, 32'h7FFF_FFFF, 32'd0, 1'b0);
    push_entry(12'd0, 12'd6, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_entry(12'd100, 12'd7, 32'd0, 32'h8000_0000, 1'b1);
    drain();

    // theta of zero: every non-zero off-diagonal entry is strong
    set_register(REG_THRESHOLD, 32'd0);
    push_entry(12'd0, 12'd1, 32'd0, 32'd1, 1'b0);
    push_entry(12'd0, 12'd2, 32'd0, 32'd0, 1'b0);
    push_entry(12'd0, 12'd2048, 32'd1, 32'd0, 1'b0);
    push_entry(12'd2048, 12'd3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    drain();

    // random phases, one per register setting
    for (p = 0; p < PHASES; p++) begin
      set_register(REG_THRESHOLD, APB_DW'(theta_list[p]));
      set_register(REG_COMPLEX, APB_DW'(mode_list[p]));
      if (p == 2) hold_request = 1'b1;
      // odd phases open with a full or overfull row
      if (p % 2 == 1) random_row(31 + (p + 1) / 2);
      // the item budget is shared out over the phases, at least one row each
      do begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(31, 35) : $urandom_range(1, 9);
        random_row(len);
      end while (random_sent < (p + 1) * RANDOM_ITEMS / PHASES);
      drain();
    end

    repeat (SETTLE) @(negedge clk);
    $display("covered %0d entry items in %0d rows, %0d of them with dropped entries",
             board.entries_in, board.rows_closed, board.rows_dropped);
    $display("checked %0d results over %0d register settings and a %0d-cycle result stall",
             board.links_checked, PHASES + 2, HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
